FILE: design/mrc16_pkg.sv
// Shared types and constants for the multiply-rotate-counter 16-bit generator.
// No dependencies; imported by the step unit and the top level.
package mrc16_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned SEED_W     = 3 * WORD_W;
    localparam int unsigned RAND_W     = 2 * WORD_W;
    localparam int unsigned ROT_AMOUNT = 10;
    localparam logic [WORD_W-1:0] MUL_CONST = 16'hA965;

    // Input beat modes
    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_NEXT = 1'b1;

    // Generator state passed between the sequencer and the step unit
    typedef struct packed {
        logic [WORD_W-1:0] mix;
        logic [WORD_W-1:0] rot;
        logic [WORD_W-1:0] ctr;
    } t_gen_state;

endpackage

FILE: design/mrc16_step.sv
// One generator step: constant multiply, rotate, Weyl increment and output sum.
// Depends on mrc16_pkg for the state struct and the constants.
module mrc16_step
    import mrc16_pkg::*;
(
    input  t_gen_state        i_cur,
    output t_gen_state        o_nxt,
    output logic [WORD_W-1:0] o_word
);

    logic [2*WORD_W-1:0] full_prod;
    logic [WORD_W-1:0]   prod;
    logic [WORD_W-1:0]   rot_l;

    // Multiply the mixing word, keep the low half
    assign full_prod = {{WORD_W{1'b0}}, i_cur.mix} * {{WORD_W{1'b0}}, MUL_CONST};
    assign prod      = full_prod[WORD_W-1:0];

    // Rotate the rotating word left
    assign rot_l = (i_cur.rot << ROT_AMOUNT) | (i_cur.rot >> (WORD_W - ROT_AMOUNT));

    // Advance the three state words and form the step output
    assign o_nxt.mix = i_cur.rot + i_cur.ctr;
    assign o_nxt.ctr = i_cur.ctr + {{(WORD_W-1){1'b0}}, 1'b1};
    assign o_nxt.rot = rot_l ^ prod;
    assign o_word    = prod + o_nxt.mix;

endmodule

FILE: design/multiply_rotate_counter_prng16.sv
// A seed beat (mode 0) loads the three 16-bit state words and runs WARMUP_STEPS
// generator steps with no result. A next beat (mode 1) runs two steps and returns
// one 32-bit word, first step in the low half. A single step unit with one 16x16
// constant multiply is reused for every step under a small sequencer, so no new
// beat enters until the steps of the last one are done. The result sits in an
// output register, so a new beat is taken while a finished word still waits; only
// the final step of a next beat waits for that register to be free.
// Depends on mrc16_pkg and mrc16_step.
module multiply_rotate_counter_prng16
    import mrc16_pkg::*;
#(
    parameter int unsigned WARMUP_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  logic [SEED_W-1:0] i_seed_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RAND_W-1:0] o_random_word
);

    localparam int unsigned MAX_STEPS = (WARMUP_STEPS > 2) ? WARMUP_STEPS : 2;
    localparam int unsigned CNT_W     = $clog2(MAX_STEPS + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_seq_state;

    t_seq_state        r_state;
    t_gen_state        r_gen;
    logic [CNT_W-1:0]  r_left;
    logic              r_is_next;
    logic [WORD_W-1:0] r_lo;
    logic              r_out_valid;
    logic [RAND_W-1:0] r_out_word;

    t_gen_state        n_gen;
    logic [WORD_W-1:0] step_word;
    logic              in_beat;
    logic              out_free;
    logic              last_step;
    logic              step_en;
    logic              out_load;

    mrc16_step u_step (
        .i_cur  (r_gen),
        .o_nxt  (n_gen),
        .o_word (step_word)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

    assign in_beat   = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign last_step = (r_left == CNT_W'(1));
    // Hold the final step of a next beat until the output register frees up
    assign step_en   = (r_state == S_RUN) && (!r_is_next || !last_step || out_free);
    assign out_load  = step_en && last_step && r_is_next;

    // Sequencer, generator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen       <= '0;
            r_left      <= '0;
            r_is_next   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished word, or drop the output beat once taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_is_next <= (i_mode == MODE_NEXT);
                        if (i_mode == MODE_NEXT) begin
                            r_left  <= CNT_W'(2);
                            r_state <= S_RUN;
                        end else begin
                            r_gen.mix <= i_seed_value[WORD_W-1:0];
                            r_gen.rot <= i_seed_value[2*WORD_W-1:WORD_W];
                            r_gen.ctr <= i_seed_value[3*WORD_W-1:2*WORD_W];
                            r_left    <= CNT_W'(WARMUP_STEPS);
                            if (WARMUP_STEPS != 0) begin
                                r_state <= S_RUN;
                            end
                        end
                    end
                end
                S_RUN: begin
                    if (step_en) begin
                        r_gen  <= n_gen;
                        r_left <= r_left - CNT_W'(1);
                        if (r_is_next && !last_step) begin
                            r_lo <= step_word;
                        end
                        if (last_step) begin
                            r_state <= S_IDLE;
                            if (r_is_next) begin
                                r_out_word <= {step_word, r_lo};
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // A next beat always occupies the step unit in the following cycle
    a_next_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_mode) |=> o_stall)
        else $error("next beat accepted but sequencer not running");

    // A new result only appears at the end of a next beat
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_is_next) && $past(r_state == S_RUN)))
        else $error("output raised outside a next beat");

    // The step counter is nonzero while running
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_left != '0))
        else $error("running with no steps left");

    // A finished word is not overwritten while it waits
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_random_word)))
        else $error("waiting result overwritten");
`endif

endmodule
